[hdl/ahdlc_pkg.sv]
// ----------------------------------------------------------------------------
// ahdlc_pkg
// Shared constants, types and the FCS-16 byte step for the async HDLC deframer.
// ----------------------------------------------------------------------------
package ahdlc_pkg;

    // Frame limit in unescaped bytes, and the counter width that can hold it
    localparam int FRAME_MAX = 512;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD = 16'hF0B8;
    localparam logic [15:0] FCS_POLY = 16'h8408;

    localparam logic [7:0] HDLC_FLAG = 8'h7E;
    localparam logic [7:0] HDLC_ESC  = 8'h7D;
    localparam logic [7:0] HDLC_XOR  = 8'h20;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       is_protocol;
        logic [8:0] payload_length;
    } t_result;

    // One byte of the reflected CRC-16 (X.25), bit at a time
    function automatic logic [15:0] fcs16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hdl/ahdlc_ifs.sv]
// ----------------------------------------------------------------------------
// ahdlc interfaces
// Valid/ready channels for line bytes in and deframer results out.
// ----------------------------------------------------------------------------
interface ahdlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ahdlc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       is_protocol;
    logic [8:0] payload_length;

    modport source (output valid, output kind, output data_byte, output is_protocol,
                    output payload_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input is_protocol,
                    input payload_length, output ready);
endinterface

[hdl/ahdlc_rx_state.sv]
// ----------------------------------------------------------------------------
// ahdlc_rx_state
// Frame state, unescape, FCS and two-byte hold line; one line byte per fire.
// ----------------------------------------------------------------------------
module ahdlc_rx_state import ahdlc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    localparam logic [1:0] MODE_HUNT  = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_ESC   = 2'd2;

    logic [1:0]       r_mode,  n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc,   n_crc;
    logic [7:0]       r_held [2];
    logic [7:0]       n_held [2];

    logic       take;
    logic [7:0] tb;

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_crc   = r_crc;
        n_held  = r_held;
        o_res   = '0;
        take    = 1'b0;
        tb      = i_byte;

        unique case (r_mode)
            MODE_FRAME: begin
                if (i_byte == HDLC_ESC) begin
                    n_mode = MODE_ESC;
                end else if (i_byte == HDLC_FLAG) begin
                    // closing flag; back-to-back flags give nothing
                    if (r_count != '0) begin
                        o_res.valid = 1'b1;
                        if (r_crc == FCS_GOOD && r_count >= CNT_W'(3)) begin
                            o_res.kind           = KIND_OK;
                            o_res.payload_length = 9'(r_count - CNT_W'(3));
                        end else begin
                            o_res.kind = KIND_BAD;
                        end
                        n_count = '0;
                        n_crc   = FCS_INIT;
                    end
                end else begin
                    take = 1'b1;
                end
            end
            MODE_ESC: begin
                take = 1'b1;
                tb   = i_byte ^ HDLC_XOR;
            end
            default: begin
                if (i_byte == HDLC_FLAG) begin
                    n_mode  = MODE_FRAME;
                    n_count = '0;
                    n_crc   = FCS_INIT;
                end
            end
        endcase

        if (take) begin
            if (r_count >= CNT_W'(FRAME_MAX)) begin
                n_mode      = MODE_HUNT;
                o_res.valid = 1'b1;
                o_res.kind  = KIND_ABORT;
            end else begin
                n_crc  = fcs16_step(r_crc, tb);
                n_mode = MODE_FRAME;
                if (r_count < CNT_W'(2)) begin
                    n_held[r_count[0]] = tb;
                end else begin
                    // oldest held byte leaves; FCS bytes stay in the hold line
                    o_res.valid       = 1'b1;
                    o_res.kind        = KIND_DATA;
                    o_res.data_byte   = r_held[0];
                    o_res.is_protocol = (r_count == CNT_W'(2));
                    n_held[0]         = r_held[1];
                    n_held[1]         = tb;
                end
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_count <= '0;
            r_crc   <= FCS_INIT;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_MAX))
        else $error("frame byte count past limit");

    a_abort_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.valid && o_res.kind == KIND_ABORT |=> r_mode == MODE_HUNT)
        else $error("abort did not drop sync");

    a_mode_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HUNT || r_mode == MODE_FRAME || r_mode == MODE_ESC)
        else $error("receive mode out of range");

endmodule

[hdl/async_hdlc_deframer_fcs16_core.sv]
// ----------------------------------------------------------------------------
// async_hdlc_deframer_fcs16_core
// Async HDLC (PPP) receive deframer with FCS-16 check, streaming output.
// ----------------------------------------------------------------------------
// Takes one raw line byte per word and sustains one word per clock while
// results are taken. A byte is captured in an input register, processed
// once the output register is free or draining (flag hunt, escape removal,
// one FCS-16 byte step, two-byte hold line) and the result, if any, lands in
// the output register. Input ready drops only while the input register holds
// a byte and the output holds an untaken word. Frame bytes come out two bytes
// late so the FCS never appears; the first is flagged as the protocol byte.
// A closing flag after a non-empty frame yields frame ok (with payload
// length, excluding protocol and FCS) or frame bad; a byte past FRAME_MAX
// yields an overflow abort and the block hunts for the next flag.
// ----------------------------------------------------------------------------
module async_hdlc_deframer_fcs16_core import ahdlc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ahdlc_in_if.sink     i_rx,
    ahdlc_out_if.source  o_res
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // output register
    logic       r_out_valid;
    t_result    r_out;

    t_result    step_res;
    logic       fire;

    // process the held byte when the output register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    ahdlc_rx_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= step_res.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_res.valid) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out.kind;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.is_protocol    = r_out.is_protocol;
    assign o_res.payload_length = r_out.payload_length;

    a_end_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != KIND_DATA |-> r_out.data_byte == 8'h00 &&
        !r_out.is_protocol)
        else $error("end result carries data fields");

    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != KIND_OK |-> r_out.payload_length == 9'd0)
        else $error("payload length outside frame ok");

    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte))
        else $error("pending input byte lost");

endmodule

[dv/async_hdlc_deframer_fcs16_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_hdlc_deframer_fcs16_core_test
// Self-checking bench for the async HDLC receive deframer. Line bytes are
// built into flagged, escaped frames with good or corrupted FCS-16, plus short
// frames, stray escapes and line noise. A scoreboard tracks the receive state
// and predicts each data word and end-of-frame status. Both channels stall
// at random.
// ----------------------------------------------------------------------------
module async_hdlc_deframer_fcs16_core_test import ahdlc_pkg::*; ();

    localparam int RUN_LIMIT   = 300000;
    localparam int RANDOM_WORDS = 250;

    typedef logic [7:0] t_octet;

    // ------------------------------------------------------------------------
    // Scoreboard: receive-side state, expected results, checking
    // ------------------------------------------------------------------------
    class deframe_scoreboard;
        typedef enum int {HUNT, IN_FRAME, AFTER_ESC} t_rx_state;
        typedef struct packed {
            logic [1:0] kind;
            logic [7:0] data_byte;
            logic       is_protocol;
            logic [8:0] payload_length;
        } t_frame_event;

        t_rx_state    state;
        int unsigned  frame_bytes;
        logic [15:0]  fcs;
        logic [7:0]   held [2];
        t_frame_event expected_q [$];
        int           mismatches;

        function new();
            state       = HUNT;
            frame_bytes = 0;
            fcs         = FCS_INIT;
            held[0]     = 8'h00;
            held[1]     = 8'h00;
            mismatches  = 0;
        endfunction

        // Reflected CRC-16, one bit per step, LSB first
        static function logic [15:0] fcs_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r  = r >> 1;
                if (fb) begin
                    r = r ^ FCS_POLY;
                end
            end
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One unescaped byte into the frame; bytes go out two behind
        local function void take(logic [7:0] b);
            t_frame_event ev;
            if (frame_bytes >= FRAME_MAX) begin
                state = HUNT;
                ev    = '{KIND_ABORT, 8'h00, 1'b0, 9'd0};
                expected_q.push_back(ev);
                return;
            end
            fcs   = fcs_update(fcs, b);
            state = IN_FRAME;
            if (frame_bytes < 2) begin
                held[frame_bytes] = b;
                frame_bytes++;
                return;
            end
            ev = '{KIND_DATA, held[0], frame_bytes == 2, 9'd0};
            expected_q.push_back(ev);
            held[0] = held[1];
            held[1] = b;
            frame_bytes++;
        endfunction

        function void note_byte(logic [7:0] b);
            t_frame_event ev;
            case (state)
                IN_FRAME: begin
                    if (b == HDLC_ESC) begin
                        state = AFTER_ESC;
                    end else if (b == HDLC_FLAG) begin
                        // back-to-back flags: nothing to report
                        if (frame_bytes != 0) begin
                            if (fcs == FCS_GOOD && frame_bytes >= 3) begin
                                ev = '{KIND_OK, 8'h00, 1'b0, 9'(frame_bytes - 3)};
                            end else begin
                                ev = '{KIND_BAD, 8'h00, 1'b0, 9'd0};
                            end
                            expected_q.push_back(ev);
                            frame_bytes = 0;
                            fcs         = FCS_INIT;
                        end
                    end else begin
                        take(b);
                    end
                end
                AFTER_ESC: begin
                    // byte after an escape is data, flag and escape included
                    take(b ^ HDLC_XOR);
                end
                default: begin
                    if (b == HDLC_FLAG) begin
                        state       = IN_FRAME;
                        frame_bytes = 0;
                        fcs         = FCS_INIT;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data_byte,
                                   logic is_protocol, logic [8:0] payload_length);
            t_frame_event want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected word: kind %0d data %02h proto %0b len %0d",
                             $realtime, kind, data_byte, is_protocol, payload_length);
                end
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind || data_byte !== want.data_byte ||
                is_protocol !== want.is_protocol ||
                payload_length !== want.payload_length) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] mismatch: exp kind %0d data %02h proto %0b len %0d",
                             $realtime, want.kind, want.data_byte, want.is_protocol,
                             want.payload_length);
                    $display("               got kind %0d data %02h proto %0b len %0d",
                             kind, data_byte, is_protocol, payload_length);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    ahdlc_in_if  rx_if ();
    ahdlc_out_if res_if ();

    async_hdlc_deframer_fcs16_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    deframe_scoreboard book;
    bit                gaps_on;
    int                words_sent;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor: sample both handshakes at the edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (res_if.valid && res_if.ready) begin
                book.check_result(res_if.kind, res_if.data_byte, res_if.is_protocol,
                                  res_if.payload_length);
            end
            if (rx_if.valid && rx_if.ready) begin
                book.note_byte(rx_if.rx_byte);
            end
        end
    end

    // Result side back-pressure in random bursts
    initial begin : result_sink
        int hold;
        hold         = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 4);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Line-side drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_octet b);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        words_sent++;
    endtask

    // Escape flag/escape always, and now and then an ordinary byte too
    task automatic send_coded(input t_octet b);
        if (b == HDLC_FLAG || b == HDLC_ESC || $urandom_range(0, 15) == 0) begin
            send_byte(HDLC_ESC);
            send_byte(b ^ HDLC_XOR);
        end else begin
            send_byte(b);
        end
    endtask

    // Opening flag, body, FCS low byte first, optional closing flag
    task automatic send_frame(input t_octet body [$], input bit fcs_ok, input bit closed);
        logic [15:0] c;
        logic [15:0] fcs_word;
        c = FCS_INIT;
        foreach (body[i]) begin
            c = deframe_scoreboard::fcs_update(c, body[i]);
        end
        fcs_word = ~c;
        if (!fcs_ok) begin
            fcs_word = fcs_word ^ 16'($urandom_range(1, 16'hFFFF));
        end
        send_byte(HDLC_FLAG);
        foreach (body[i]) begin
            send_coded(body[i]);
        end
        send_coded(fcs_word[7:0]);
        send_coded(fcs_word[15:8]);
        if (closed) begin
            send_byte(HDLC_FLAG);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_octet payload [$];
        t_octet opening [];
        int     start;
        int     left;
        int     pick;
        int     len;

        opening       = '{8'h00, 8'hFF, HDLC_ESC, HDLC_FLAG, HDLC_FLAG,
                          8'h11, HDLC_FLAG, 8'h22, 8'h33, HDLC_FLAG,
                          8'h01, HDLC_ESC, HDLC_FLAG, HDLC_ESC, HDLC_ESC,
                          8'h80, HDLC_FLAG};
        book          = new();
        gaps_on       = 1'b1;
        words_sent    = 0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while hunting, empty frame, 1- and 2-byte frames,
        // flag and escape taken as data after an escape
        foreach (opening[i]) begin
            send_byte(opening[i]);
        end

        // shortest good frame (payload length 0), good frame with specials,
        // bad FCS
        payload = {8'h21};
        send_frame(payload, 1'b1, 1'b1);
        payload = {8'hC0, HDLC_FLAG, HDLC_ESC, 8'hFF, 8'h00};
        send_frame(payload, 1'b1, 1'b1);
        payload = {8'h57, 8'hA8};
        send_frame(payload, 1'b0, 1'b1);

        // frame right at the limit, then one whose body alone is one byte over it
        payload.delete();
        repeat (FRAME_MAX - 2) payload.push_back(t_octet'($urandom));
        send_frame(payload, 1'b1, 1'b1);
        payload.delete();
        repeat (FRAME_MAX + 1) payload.push_back(t_octet'($urandom));
        send_frame(payload, 1'b1, 1'b0);
        // back to hunting: all of this is ignored until the flag
        payload = {8'h00, 8'h55, HDLC_ESC, 8'hFF};
        foreach (payload[i]) begin
            send_byte(payload[i]);
        end

        // random traffic, mostly well-formed frames
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            left = RANDOM_WORDS - (words_sent - start);
            if (left < 60) begin
                gaps_on = 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                               : $urandom_range(1, 24);
            payload.delete();
            repeat (len) payload.push_back(t_octet'($urandom));
            if (pick < 65) begin
                send_frame(payload, 1'b1, 1'b1);
            end else if (pick < 77) begin
                send_frame(payload, 1'b0, 1'b1);
            end else if (pick < 85) begin
                send_byte(HDLC_FLAG);
                repeat ($urandom_range(1, 2)) send_coded(t_octet'($urandom));
                send_byte(HDLC_FLAG);
            end else if (pick < 92) begin
                // dangling escape swallows the closing flag
                send_frame(payload, 1'b1, 1'b0);
                send_byte(HDLC_ESC);
                send_byte(HDLC_FLAG);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(t_octet'($urandom));
            end
        end
        send_byte(HDLC_FLAG);
        rx_if.valid <= 1'b0;
        gaps_on = 1'b0;

        @(posedge i_clk);
        while (book.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[async_hdlc_deframer_fcs16_core.f]
hdl/ahdlc_pkg.sv
hdl/ahdlc_ifs.sv
hdl/ahdlc_rx_state.sv
hdl/async_hdlc_deframer_fcs16_core.sv
dv/async_hdlc_deframer_fcs16_core_test.sv
